// ===== src/crsp_pkg.sv =====
// Shared types, constants and codes for the Catmull-Rom spline point block.
package crsp_pkg;

    // Default build values
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths
    localparam int LOC_W      = 24;
    localparam int COORD_W    = 32;
    localparam int PT_IDX_W   = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Internal command widths, sized for the largest build (4096 points, 24 fraction bits)
    localparam int IDX_W_MAX = 12;
    localparam int WT_W      = 28;
    localparam int PROD_W    = COORD_W + WT_W;
    localparam int ACC_W     = 38;

    // Queue depths (powers of two)
    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 2'd1;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [PT_IDX_W-1:0]       point_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [LOC_W-1:0]          location;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      at_end;
    } res_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EVAL,
        CMD_HOLD
    } cmd_kind_t;

    // Work handed from the front end to the back end
    typedef struct packed {
        cmd_kind_t                  kind;
        logic [3:0][IDX_W_MAX-1:0]  idx;
        logic [3:0][WT_W-1:0]       wt;
        point_t                     pt;
    } cmd_t;

endpackage

// ===== src/crsp_fifo.sv =====
// Small register queue; DEPTH must be a power of two.
module crsp_fifo
    import crsp_pkg::*;
#(
    parameter type elem_t = cmd_t,
    parameter int  DEPTH  = CMD_Q_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  elem_t wr_data,
    output logic  full,
    input  logic  pop,
    output elem_t rd_data,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    elem_t           mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/crsp_ram.sv =====
// Generic single-port RAM with registered read.
module crsp_ram
#(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

endmodule

// ===== src/crsp_front.sv =====
// Front end: accepts items, computes basis weights and point indices, queues commands.
module crsp_front
    import crsp_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    input  logic [CFG_DATA_W-1:0] point_count,
    input  logic                  loop_enable,
    output logic                  cmd_push,
    input  logic                  cmd_full,
    output cmd_t                  cmd
);

    localparam int WHW_RAW = LOC_W - FRAC_BITS;
    localparam int WHW     = (WHW_RAW > 0) ? WHW_RAW : 1;
    localparam int NW      = $clog2(MAX_POINTS + 1);
    localparam int QW      = FRAC_BITS + 4;
    localparam int CALC_N  = (WHW > 3) ? WHW : 3;
    localparam int SW      = $clog2(CALC_N + 1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_IDX,
        F_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [SW-1:0]        step_reg, step_next;

    logic [FRAC_BITS-1:0] t_reg, t_next;
    logic [FRAC_BITS-1:0] tt_reg, tt_next;
    logic [FRAC_BITS-1:0] ttt_reg, ttt_next;
    logic [WHW-1:0]       whole_reg, whole_next;
    logic [WHW-1:0]       whole_sh_reg, whole_sh_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        rem_reg, rem_next;
    logic                 loop_reg, loop_next;
    logic                 mod_skip_reg, mod_skip_next;
    cmd_t                 cmd_reg, cmd_next;

    logic [LOC_W-1:0]       loc_whole;
    logic [WHW-1:0]         whole_in;
    logic [31:0]            pc32, n_sel, whole_in32;
    logic [2*FRAC_BITS-1:0] t_sq, t_cu;
    logic signed [QW-1:0]   t_q, tt_q, ttt_q, two_q;
    logic signed [QW-1:0]   q0, q1, q2, q3;
    logic [NW:0]            rem_sh, n_ext, rem_step;
    logic                   calc_done, mod_active;
    logic [31:0]            whole32, n32, i0, i1, i2, i3;

    assign full     = (state_reg != F_IDLE);
    assign cmd_push = (state_reg == F_EMIT);
    assign cmd      = cmd_reg;

    // Item decode
    assign loc_whole  = item.location >> FRAC_BITS;
    assign whole_in   = loc_whole[WHW-1:0];
    assign whole_in32 = 32'(whole_in);
    assign pc32       = 32'(point_count);
    assign n_sel      = (pc32 < 32'd4) ? 32'd4 :
                        (pc32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : pc32;

    // Powers of t, truncated
    assign t_sq = t_reg * t_reg;
    assign t_cu = tt_reg * t_reg;

    // Basis weights
    assign t_q   = $signed({4'b0000, t_reg});
    assign tt_q  = $signed({4'b0000, tt_reg});
    assign ttt_q = $signed({4'b0000, ttt_reg});
    assign two_q = $signed(QW'(2) << FRAC_BITS);
    assign q0 = -ttt_q + (tt_q <<< 1) - t_q;
    assign q1 = (ttt_q <<< 1) + ttt_q - ((tt_q <<< 2) + tt_q) + two_q;
    assign q2 = -((ttt_q <<< 1) + ttt_q) + (tt_q <<< 2) + t_q;
    assign q3 = ttt_q - tt_q;

    // One restoring step of whole % n
    assign rem_sh   = {rem_reg, whole_sh_reg[WHW-1]};
    assign n_ext    = {1'b0, n_reg};
    assign rem_step = (rem_sh >= n_ext) ? rem_sh - n_ext : rem_sh;

    assign mod_active = !mod_skip_reg && (32'(step_reg) < WHW);
    assign calc_done  = (32'(step_reg) >= 2) &&
                        (mod_skip_reg || (32'(step_reg) >= WHW - 1));

    // Index set
    assign whole32 = 32'(whole_reg);
    assign n32     = 32'(n_reg);
    assign i1      = loop_reg ? 32'(rem_reg) : whole32 + 32'd1;
    assign i2      = loop_reg ? ((i1 + 32'd1 == n32) ? 32'd0 : i1 + 32'd1) : whole32 + 32'd2;
    assign i3      = loop_reg ? ((i2 + 32'd1 == n32) ? 32'd0 : i2 + 32'd1) : whole32 + 32'd3;
    assign i0      = loop_reg ? ((i1 >= 32'd1) ? i1 - 32'd1 : n32 - 32'd1) : whole32;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        t_next        = t_reg;
        tt_next       = tt_reg;
        ttt_next      = ttt_reg;
        whole_next    = whole_reg;
        whole_sh_next = whole_sh_reg;
        n_next        = n_reg;
        rem_next      = rem_reg;
        loop_next     = loop_reg;
        mod_skip_next = mod_skip_reg;
        cmd_next      = cmd_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    if (item.mode == MODE_WRITE)
                    begin
                        cmd_next.kind   = CMD_WRITE;
                        cmd_next.idx[0] = IDX_W_MAX'(item.point_index);
                        cmd_next.pt     = {item.coord_x, item.coord_y, item.coord_z};
                        // entries beyond the table are dropped
                        if (32'(item.point_index) < MAX_POINTS)
                        begin
                            state_next = F_EMIT;
                        end
                    end
                    else
                    begin
                        t_next        = item.location[FRAC_BITS-1:0];
                        whole_next    = whole_in;
                        whole_sh_next = whole_in;
                        n_next        = n_sel[NW-1:0];
                        loop_next     = loop_enable;
                        mod_skip_next = !loop_enable || (whole_in32 < n_sel);
                        rem_next      = (whole_in32 < n_sel) ? whole_in32[NW-1:0] : '0;
                        step_next     = '0;
                        state_next    = F_CALC;
                    end
                end
            end
            F_CALC:
            begin
                if (step_reg == SW'(0))
                begin
                    tt_next = t_sq[2*FRAC_BITS-1:FRAC_BITS];
                end
                if (step_reg == SW'(1))
                begin
                    ttt_next = t_cu[2*FRAC_BITS-1:FRAC_BITS];
                end
                if (step_reg == SW'(2))
                begin
                    cmd_next.wt[0] = WT_W'(q0);
                    cmd_next.wt[1] = WT_W'(q1);
                    cmd_next.wt[2] = WT_W'(q2);
                    cmd_next.wt[3] = WT_W'(q3);
                end
                if (mod_active)
                begin
                    rem_next      = rem_step[NW-1:0];
                    whole_sh_next = whole_sh_reg << 1;
                end
                if (calc_done)
                begin
                    state_next = F_IDX;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            F_IDX:
            begin
                if (!loop_reg && (whole32 >= n32 - 32'd4))
                begin
                    // open path past its end: hold at the next-to-last point
                    cmd_next.kind   = CMD_HOLD;
                    cmd_next.idx[0] = IDX_W_MAX'(n32 - 32'd2);
                end
                else
                begin
                    cmd_next.kind   = CMD_EVAL;
                    cmd_next.idx[0] = IDX_W_MAX'(i0);
                    cmd_next.idx[1] = IDX_W_MAX'(i1);
                    cmd_next.idx[2] = IDX_W_MAX'(i2);
                    cmd_next.idx[3] = IDX_W_MAX'(i3);
                end
                state_next = F_EMIT;
            end
            F_EMIT:
            begin
                if (!cmd_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        tt_reg       <= tt_next;
        ttt_reg      <= ttt_next;
        whole_reg    <= whole_next;
        whole_sh_reg <= whole_sh_next;
        n_reg        <= n_next;
        rem_reg      <= rem_next;
        loop_reg     <= loop_next;
        mod_skip_reg <= mod_skip_next;
        cmd_reg      <= cmd_next;
    end

endmodule

// ===== src/crsp_back.sv =====
// Back end: owns the point table, runs writes and the four-point weighted sum.
module crsp_back
    import crsp_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    output logic      res_push,
    input  logic      res_full,
    output res_item_t res
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = $bits(point_t);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_HOLD,
        B_PUSH
    } state_t;

    state_t    state_reg, state_next;
    logic [2:0] step_reg, step_next;
    cmd_t      cmd_reg, cmd_next;
    res_item_t res_reg, res_next;

    logic signed [ACC_W-1:0] prod_reg [3];
    logic signed [ACC_W-1:0] prod_next [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];

    logic            ram_en, ram_we;
    logic [AW-1:0]   ram_addr;
    logic [PW-1:0]   ram_rdata;
    point_t          rd_pt;
    logic [2:0]      step_m1;
    logic [WT_W-1:0] wsel;

    logic signed [COORD_W-1:0] coord [3];
    logic signed [PROD_W-1:0]  prod_full [3];
    logic signed [PROD_W-1:0]  prod_sh [3];
    logic signed [ACC_W-1:0]   half [3];

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
        lo = $signed({{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    crsp_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.pt),
        .rdata (ram_rdata)
    );

    assign rd_pt    = point_t'(ram_rdata);
    assign coord[0] = rd_pt.x;
    assign coord[1] = rd_pt.y;
    assign coord[2] = rd_pt.z;

    assign step_m1  = step_reg - 3'd1;
    assign wsel     = cmd_reg.wt[step_m1[1:0]];

    assign cmd_pop  = (state_reg == B_IDLE) && !cmd_empty;
    assign res_push = (state_reg == B_PUSH);
    assign res      = res_reg;

    // Table port: first read (or the write) issues from the queue head at pop,
    // the other three reads follow from the held command.
    always_comb
    begin
        if (state_reg == B_IDLE)
        begin
            ram_en   = cmd_pop;
            ram_we   = cmd_pop && (cmd.kind == CMD_WRITE);
            ram_addr = cmd.idx[0][AW-1:0];
        end
        else
        begin
            ram_en   = (state_reg == B_RUN) && (step_reg <= 3'd3);
            ram_we   = 1'b0;
            ram_addr = cmd_reg.idx[step_reg[1:0]][AW-1:0];
        end
    end

    // Per-axis product, floor-shifted, and final halving
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_full[a] = $signed(coord[a]) * $signed(wsel);
            prod_sh[a]   = prod_full[a] >>> FRAC_BITS;
            half[a]      = acc_reg[a] >>> 1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        for (int a = 0; a < 3; a++)
        begin
            prod_next[a] = prod_reg[a];
            acc_next[a]  = acc_reg[a];
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_pop)
                begin
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        CMD_EVAL:
                        begin
                            step_next  = 3'd1;
                            state_next = B_RUN;
                        end
                        CMD_HOLD:
                        begin
                            state_next = B_HOLD;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_RUN:
            begin
                // steps 1-4 multiply, 2-5 accumulate, 6 rounds out
                for (int a = 0; a < 3; a++)
                begin
                    if (step_reg <= 3'd4)
                    begin
                        prod_next[a] = prod_sh[a][ACC_W-1:0];
                    end
                    if (step_reg == 3'd1)
                    begin
                        acc_next[a] = '0;
                    end
                    else if (step_reg <= 3'd5)
                    begin
                        acc_next[a] = acc_reg[a] + prod_reg[a];
                    end
                end
                if (step_reg == 3'd6)
                begin
                    res_next.pos_x  = sat32(half[0]);
                    res_next.pos_y  = sat32(half[1]);
                    res_next.pos_z  = sat32(half[2]);
                    res_next.at_end = 1'b0;
                    state_next      = B_PUSH;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            B_HOLD:
            begin
                res_next.pos_x  = rd_pt.x;
                res_next.pos_y  = rd_pt.y;
                res_next.pos_z  = rd_pt.z;
                res_next.at_end = 1'b1;
                state_next      = B_PUSH;
            end
            B_PUSH:
            begin
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        for (int a = 0; a < 3; a++)
        begin
            prod_reg[a] <= prod_next[a];
            acc_reg[a]  <= acc_next[a];
        end
    end

endmodule

// ===== src/catmull_rom_spline_point_top.sv =====
// Top level of the uniform Catmull-Rom spline point evaluator.
//
// Holds a table of 3D control points (signed Q16.16) and evaluates a uniform
// Catmull-Rom position at an unsigned path location with FRAC_BITS fraction bits.
// A write item (mode 0) stores one point and gives no result; an evaluate item
// (mode 1) gives exactly one result, in order. Both sides look like queues: an
// item is taken when push is high and full is low, a result is taken when pop is
// high and empty is low. The front end accepts an item in F_IDLE; an evaluate
// item then passes F_CALC, which forms t^2, t^3 and the weights and also waits
// for the remainder when a looping path has to reduce a location at or past
// point_count, since that comes from a one-bit-per-cycle restoring divider;
// then F_IDX forms the indices and F_EMIT hands the command on. The back end
// reads the four control points through the single table port and runs one
// multiply per axis per point in B_RUN; a held end point passes B_HOLD, and a
// write completes at pop. Front and back overlap through a two-entry command
// queue, so the front end can take a new item while the back end works on an
// earlier command; results sit in a two-entry queue so the block keeps working
// while the consumer stalls. Config writes take effect at once and should be
// made only while the block is idle.
module catmull_rom_spline_point_top
    import crsp_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item side
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output res_item_t             result,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] point_count_reg;
    logic                  loop_enable_reg;

    // front -> command queue -> back
    logic      fe_push, cq_full;
    cmd_t      fe_cmd, cq_cmd;
    logic      cq_empty, be_pop;
    // back -> result queue
    logic      be_push, rq_full;
    res_item_t be_res;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CFG_DATA_W'(4);
            loop_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_COUNT: point_count_reg <= cfg_data;
                REG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Front end: classify, weights, indices (and wrap divider)
    crsp_front #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .point_count (point_count_reg),
        .loop_enable (loop_enable_reg),
        .cmd_push    (fe_push),
        .cmd_full    (cq_full),
        .cmd         (fe_cmd)
    );

    // Decoupling queue between front and back
    crsp_fifo #(
        .elem_t (cmd_t),
        .DEPTH  (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_push),
        .wr_data (fe_cmd),
        .full    (cq_full),
        .pop     (be_pop),
        .rd_data (cq_cmd),
        .empty   (cq_empty)
    );

    // Back end: point table and weighted sum
    crsp_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd_pop   (be_pop),
        .cmd       (cq_cmd),
        .res_push  (be_push),
        .res_full  (rq_full),
        .res       (be_res)
    );

    // Result queue seen by the consumer
    crsp_fifo #(
        .elem_t (res_item_t),
        .DEPTH  (RES_Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (be_push),
        .wr_data (be_res),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== src/crsp_checker.sv =====
// Port-level checker for the spline point block, bound to the top level.
module crsp_checker
    import crsp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      empty,
    input logic      pop,
    input res_item_t result
);

    // A waiting result that is not taken stays put
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result))
    ) else $error("result changed or vanished while waiting");

    // An evaluate item keeps the front end busy for at least the next cycle
    a_eval_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !full && item.mode == MODE_EVAL) |=> full
    ) else $error("front end free right after taking an evaluate item");

    // Out of reset both sides are clear
    a_reset_clear: assert property (
        @(posedge clk)
        $rose(rst_n) |-> (empty && !full)
    ) else $error("queues not clear after reset");

endmodule

bind catmull_rom_spline_point_top crsp_checker u_chk (.*);
